/* sv/calendar_date_counter_unit_defines.svh */
// ----------------------------------------------------------------------------
// calendar date counter assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_COUNTER_UNIT_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication
`define CDC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("calendar date counter check failed");

// next-cycle implication
`define CDC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("calendar date counter check failed");

`endif

/* sv/cdc_pkg.sv */
// ----------------------------------------------------------------------------
// cdc_pkg
// types, constants and tables shared by the calendar date counter
// ----------------------------------------------------------------------------
`default_nettype none

package cdc_pkg;

  localparam int YEAR_MIN = 1;
  localparam int YEAR_MAX = 9999;

  localparam int CQ_DEPTH  = 2;
  localparam int CQ_AW     = $clog2(CQ_DEPTH);
  localparam int CQ_CW     = $clog2(CQ_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x below 43690
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;

  typedef enum logic [1:0] {
    FUNC_HOLD = 2'd0,
    FUNC_NEXT = 2'd1,
    FUNC_PREV = 2'd2,
    FUNC_LOAD = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
  } in_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic [2:0]  weekday;
    logic        leap;
    logic [4:0]  month_length;
    logic        range_hit;
  } out_t;

  // classified command: loaded year already split into century and remainder
  typedef struct packed {
    func_t       func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [7:0]  cent;
    logic [6:0]  yrem;
  } cmd_t;

  function automatic logic is_leap(input logic [6:0] yrem, input logic [7:0] cent);
    is_leap = (yrem[1:0] == 2'd0) && ((yrem != 7'd0) || (cent[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
      4'd2:                                       month_len = leap ? 5'd29 : 5'd28;
      default:                                    month_len = 5'd31;
    endcase
  endfunction

  // 13 * (ma + 1) / 5, january and february counted as months 13 and 14
  function automatic logic [5:0] zeller_month(input logic [3:0] m);
    case (m)
      4'd0:    zeller_month = 6'd33;
      4'd1:    zeller_month = 6'd36;
      4'd2:    zeller_month = 6'd39;
      4'd3:    zeller_month = 6'd10;
      4'd4:    zeller_month = 6'd13;
      4'd5:    zeller_month = 6'd15;
      4'd6:    zeller_month = 6'd18;
      4'd7:    zeller_month = 6'd20;
      4'd8:    zeller_month = 6'd23;
      4'd9:    zeller_month = 6'd26;
      4'd10:   zeller_month = 6'd28;
      4'd11:   zeller_month = 6'd31;
      4'd12:   zeller_month = 6'd33;
      4'd13:   zeller_month = 6'd36;
      4'd14:   zeller_month = 6'd39;
      default: zeller_month = 6'd41;
    endcase
  endfunction

endpackage

`default_nettype wire

/* sv/calendar_date_counter_unit.sv */
// beats pass the registered command queue, snapshot stage and result queue
// throughput: one beat per cycle unless the result queue fills and stalls the back
// the input queue holds two commands, the result queue four results
// reset: synchronous, date set to 1 january 1000, both queues emptied
// ----------------------------------------------------------------------------
// calendar_date_counter_unit
// gregorian date counter with zeller weekday, queue interfaces on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_counter_unit
  import cdc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  cmd,
  output logic empty,
  input  logic pop,
  output out_t result
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_take;

  cdc_front u_front (
    .item (cmd),
    .cmd  (front_cmd)
  );

  cdc_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (push),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_valid (q_valid),
    .rd       (q_take),
    .rd_data  (q_cmd)
  );

  cdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_take  (q_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

/* sv/cdc_front.sv */
// ----------------------------------------------------------------------------
// cdc_front
// classifies an incoming beat and splits the load year into century and
// remainder by a reciprocal multiply
// ----------------------------------------------------------------------------
`default_nettype none

module cdc_front
  import cdc_pkg::*;
(
  input  in_t  item,
  output cmd_t cmd
);

  logic [26:0] prod;
  logic [7:0]  q;
  logic [13:0] hundreds;
  logic [13:0] rem;

  always_comb begin
    prod     = 27'(item.load_year) * 27'(DIV100_MUL);
    q        = prod[DIV100_SHIFT +: 8];
    hundreds = (14'(q) << 6) + (14'(q) << 5) + (14'(q) << 2);
    rem      = item.load_year - hundreds;

    cmd.func  = func_t'(item.func);
    cmd.day   = item.load_day;
    cmd.month = item.load_month;
    cmd.year  = item.load_year;
    cmd.cent  = q;
    cmd.yrem  = rem[6:0];
  end

endmodule

`default_nettype wire

/* sv/cdc_cmd_queue.sv */
// ----------------------------------------------------------------------------
// cdc_cmd_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module cdc_cmd_queue
  import cdc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic full,
  output logic rd_valid,
  input  logic rd,
  output cmd_t rd_data
);

  cmd_t              mem [CQ_DEPTH];
  logic [CQ_AW-1:0]  wr_ptr;
  logic [CQ_AW-1:0]  rd_ptr;
  logic [CQ_CW-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full     = (count == CQ_CW'(CQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/cdc_back.sv */
// ----------------------------------------------------------------------------
// cdc_back
// date register and step logic, weekday stage and result queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_counter_unit_defines.svh"

module cdc_back
  import cdc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic empty,
  input  logic pop,
  output out_t result
);

  // date state, year also kept as century and remainder
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [7:0]  cent;
  logic [6:0]  yrem;

  logic [4:0]  day_next;
  logic [3:0]  month_next;
  logic [13:0] year_next;
  logic [7:0]  cent_next;
  logic [6:0]  yrem_next;
  logic        hit_next;

  logic        cur_leap;
  logic [4:0]  cur_len;
  logic [5:0]  day_inc;

  // snapshot stage
  logic        s1_valid;
  logic [4:0]  s1_day;
  logic [3:0]  s1_month;
  logic [13:0] s1_year;
  logic [7:0]  s1_cent;
  logic [6:0]  s1_yrem;
  logic        s1_hit;

  // result queue
  out_t              mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic [OUT_CW-1:0] out_count;
  logic              do_pop;

  out_t        res;
  logic        s1_leap;
  logic [6:0]  zk;
  logic [7:0]  zj;
  logic [10:0] zsum;
  logic [4:0]  r1;
  logic [3:0]  r2;

  assign cur_leap = is_leap(yrem, cent);
  assign cur_len  = month_len(month, cur_leap);
  assign day_inc  = {1'b0, day} + 6'd1;

  assign cmd_take = cmd_valid &&
                    (({1'b0, out_count} + (OUT_CW + 1)'(s1_valid)) < (OUT_CW + 1)'(OUT_DEPTH));

  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    cent_next  = cent;
    yrem_next  = yrem;
    hit_next   = 1'b0;
    unique case (cmd.func)
      FUNC_HOLD: begin
      end
      FUNC_NEXT: begin
        if (day_inc > {1'b0, cur_len}) begin
          if (month >= 4'd12) begin
            if (year >= 14'(YEAR_MAX)) begin
              hit_next = 1'b1;
            end else begin
              day_next   = 5'd1;
              month_next = 4'd1;
              year_next  = year + 14'd1;
              if (yrem == 7'd99) begin
                yrem_next = 7'd0;
                cent_next = cent + 8'd1;
              end else begin
                yrem_next = yrem + 7'd1;
              end
            end
          end else begin
            day_next   = 5'd1;
            month_next = month + 4'd1;
          end
        end else begin
          day_next = day_inc[4:0];
        end
      end
      FUNC_PREV: begin
        if (day > 5'd1) begin
          day_next = day - 5'd1;
        end else if (month <= 4'd1) begin
          if (year <= 14'(YEAR_MIN)) begin
            hit_next = 1'b1;
          end else begin
            month_next = 4'd12;
            day_next   = month_len(4'd12, 1'b0);
            year_next  = year - 14'd1;
            if (yrem == 7'd0) begin
              yrem_next = 7'd99;
              cent_next = cent - 8'd1;
            end else begin
              yrem_next = yrem - 7'd1;
            end
          end
        end else begin
          month_next = month - 4'd1;
          day_next   = month_len(month - 4'd1, cur_leap);
        end
      end
      FUNC_LOAD: begin
        day_next   = cmd.day;
        month_next = cmd.month;
        year_next  = cmd.year;
        cent_next  = cmd.cent;
        yrem_next  = cmd.yrem;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day      <= 5'd1;
      month    <= 4'd1;
      year     <= 14'd1000;
      cent     <= 8'd10;
      yrem     <= 7'd0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_take;
      if (cmd_take) begin
        day   <= day_next;
        month <= month_next;
        year  <= year_next;
        cent  <= cent_next;
        yrem  <= yrem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_day   <= day_next;
      s1_month <= month_next;
      s1_year  <= year_next;
      s1_cent  <= cent_next;
      s1_yrem  <= yrem_next;
      s1_hit   <= hit_next;
    end
  end

  // zeller on year + 400, month shift for january and february
  always_comb begin
    s1_leap = is_leap(s1_yrem, s1_cent);
    if (s1_month < 4'd3) begin
      if (s1_yrem == 7'd0) begin
        zk = 7'd99;
        zj = s1_cent + 8'd3;
      end else begin
        zk = s1_yrem - 7'd1;
        zj = s1_cent + 8'd4;
      end
    end else begin
      zk = s1_yrem;
      zj = s1_cent + 8'd4;
    end
    zsum = 11'(s1_day) + 11'(zeller_month(s1_month)) + 11'(zk) + 11'(zk >> 2)
         + 11'(zj >> 2) + (11'(zj) << 2) + 11'(zj);
    // mod 7 by folding octal digits
    r1 = 5'(zsum[2:0]) + 5'(zsum[5:3]) + 5'(zsum[8:6]) + 5'(zsum[10:9]);
    r2 = 4'(r1[2:0]) + 4'(r1[4:3]);

    res.cur_day      = s1_day;
    res.cur_month    = s1_month;
    res.cur_year     = s1_year;
    res.weekday      = (r2 >= 4'd7) ? 3'(r2 - 4'd7) : r2[2:0];
    res.leap         = s1_leap;
    res.month_length = month_len(s1_month, s1_leap);
    res.range_hit    = s1_hit;
  end

  assign empty  = (out_count == '0);
  assign result = mem[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (s1_valid && !do_pop) begin
        out_count <= out_count + 1'b1;
      end else if (do_pop && !s1_valid) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  `CDC_ASSERT_NEXT(a_hit_holds_date, cmd_take && hit_next, (day == $past(day)) && (month == $past(month)) && (year == $past(year)))
  `CDC_ASSERT_NOW(a_year_split, 1'b1, (32'(year) == (32'(cent) * 32'd100 + 32'(yrem))))
  `CDC_ASSERT_NOW(a_no_overflow, s1_valid, (out_count < OUT_CW'(OUT_DEPTH)))
  `CDC_ASSERT_NEXT(a_snapshot_tracks, cmd_take, (s1_valid && (s1_day == day) && (s1_year == year)))

endmodule

`default_nettype wire

/* verif/calendar_date_counter_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_counter_unit_test
// drives hold, next, previous and load commands through the input queue and
// checks every result beat against a date tracker kept in the bench: date,
// zeller weekday, leap flag, month length and year range flag
// ----------------------------------------------------------------------------

module calendar_date_counter_unit_test;
  import cdc_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int QUIET_LIMIT  = 4000;
  localparam int IN_W         = $bits(in_t);

  class calendar_book;
    bit [4:0]  day;
    bit [3:0]  month;
    bit [13:0] year;
    out_t      expected_dates[$];
    int        errors;

    function new();
      day    = 5'd1;
      month  = 4'd1;
      year   = 14'd1000;
      errors = 0;
    endfunction

    function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int days_in(int m, int y);
      case (m)
        2:          return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:    return 31;
      endcase
    endfunction

    function int zeller_day(int d, int m, int y);
      int ya, ma, k, j;
      ya = y + 400;
      ma = m;
      if (ma < 3) begin
        ma = ma + 12;
        ya = ya - 1;
      end
      k = ya % 100;
      j = ya / 100;
      return (d + 13 * (ma + 1) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    endfunction

    function void note_command(in_t c);
      int   d, m, y;
      bit   hit;
      out_t e;
      d   = int'(day);
      m   = int'(month);
      y   = int'(year);
      hit = 1'b0;
      case (func_t'(c.func))
        FUNC_NEXT: begin
          d = d + 1;
          if (d > days_in(m, y)) begin
            d = 1;
            m = m + 1;
            if (m > 12) begin
              m = 1;
              if (y >= YEAR_MAX) hit = 1'b1;
              else y = y + 1;
            end
          end
        end
        FUNC_PREV: begin
          if (d > 1) begin
            d = d - 1;
          end else begin
            if (m <= 1) begin
              m = 12;
              if (y <= YEAR_MIN) hit = 1'b1;
              else y = y - 1;
            end else begin
              m = m - 1;
            end
            if (!hit) d = days_in(m, y);
          end
        end
        FUNC_LOAD: begin
          d = int'(c.load_day);
          m = int'(c.load_month);
          y = int'(c.load_year);
        end
        default: ;
      endcase
      if (!hit) begin
        day   = 5'(d);
        month = 4'(m);
        year  = 14'(y);
      end
      e.cur_day      = day;
      e.cur_month    = month;
      e.cur_year     = year;
      e.weekday      = 3'(zeller_day(int'(day), int'(month), int'(year)));
      e.leap         = leap_year(int'(year));
      e.month_length = 5'(days_in(int'(month), int'(year)));
      e.range_hit    = hit;
      expected_dates.push_back(e);
    endfunction

    function void field_check(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
        errors++;
        $display("%t mismatch %s: expected %0d, actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_result(out_t r);
      out_t e;
      if (expected_dates.size() == 0) begin
        errors++;
        $display("%t unexpected result beat: expected none, actual %h", $time, r);
        return;
      end
      e = expected_dates.pop_front();
      field_check("cur_day", 16'(e.cur_day), 16'(r.cur_day));
      field_check("cur_month", 16'(e.cur_month), 16'(r.cur_month));
      field_check("cur_year", 16'(e.cur_year), 16'(r.cur_year));
      field_check("weekday", 16'(e.weekday), 16'(r.weekday));
      field_check("leap", 16'(e.leap), 16'(r.leap));
      field_check("month_length", 16'(e.month_length), 16'(r.month_length));
      field_check("range_hit", 16'(e.range_hit), 16'(r.range_hit));
    endfunction
  endclass

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic pop  = 1'b0;
  in_t  cmd  = '0;
  logic full;
  logic empty;
  out_t result;

  bit   steady  = 1'b0;
  bit   took_in = 1'b0;
  int   quiet   = 0;
  calendar_book book;

  calendar_date_counter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    pop <= steady || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    took_in = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        took_in = 1'b1;
        book.note_command(cmd);
      end
      if (pop && !empty) begin
        book.check_result(result);
        quiet = 0;
      end else if (took_in) begin
        quiet = 0;
      end else if (push || book.expected_dates.size() != 0) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("calendar_date_counter_unit_test NOT OK");
    $finish;
  end

  function automatic in_t load_cmd(int d, int m, int y);
    in_t c;
    c.func       = FUNC_LOAD;
    c.load_day   = 5'(d);
    c.load_month = 4'(m);
    c.load_year  = 14'(y);
    return c;
  endfunction

  // load fields carry junk on non-load commands
  function automatic in_t step_cmd(func_t f);
    in_t c;
    c      = IN_W'($urandom);
    c.func = f;
    return c;
  endfunction

  task automatic send_beat(in_t c);
    while (!steady && $urandom_range(99) < 28) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    cmd  = c;
    do @(negedge clk); while (!took_in);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (book.expected_dates.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_t c;
    int  r, y, m, d;
    book = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_beat(step_cmd(FUNC_HOLD));
    send_beat(load_cmd(31, 12, 9999));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(load_cmd(1, 1, 1));
    send_beat(step_cmd(FUNC_PREV));
    send_beat(load_cmd(28, 2, 2000));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(load_cmd(28, 2, 1900));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(load_cmd(1, 3, 2024));
    send_beat(step_cmd(FUNC_PREV));
    send_beat(load_cmd(31, 12, 1999));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(load_cmd(0, 0, 0));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(step_cmd(FUNC_PREV));
    send_beat(load_cmd(31, 15, 16383));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(step_cmd(FUNC_PREV));
    send_beat(load_cmd(31, 13, 0));
    send_beat(step_cmd(FUNC_NEXT));
    send_beat(load_cmd(30, 4, 12000));
    send_beat(step_cmd(FUNC_NEXT));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady <= (i >= 400) && (i < 560);
      r = $urandom_range(99);
      if (r < 32) begin
        c = step_cmd(FUNC_NEXT);
      end else if (r < 58) begin
        c = step_cmd(FUNC_PREV);
      end else if (r < 66) begin
        c = step_cmd(FUNC_HOLD);
      end else if (r < 73) begin
        c = step_cmd(FUNC_LOAD);
      end else begin
        case ($urandom_range(5))
          0:       y = $urandom_range(1, 3);
          1:       y = $urandom_range(9997, 9999);
          2:       y = $urandom_range(4, 99) * 100;
          3:       y = $urandom_range(1, 9999);
          default: y = $urandom_range(1990, 2030);
        endcase
        m = $urandom_range(1, 12);
        if ($urandom_range(1)) d = book.days_in(m, y) - $urandom_range(1);
        else d = $urandom_range(1, book.days_in(m, y));
        c = load_cmd(d, m, y);
      end
      send_beat(c);
      if ($urandom_range(199) == 0) wait_drained();
    end
    steady <= 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);
    if (book.errors == 0 && book.expected_dates.size() == 0) begin
      $display("calendar_date_counter_unit_test OK");
    end else begin
      $display("calendar_date_counter_unit_test NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/cdc_pkg.sv
sv/cdc_front.sv
sv/cdc_cmd_queue.sv
sv/cdc_back.sv
sv/calendar_date_counter_unit.sv
verif/calendar_date_counter_unit_test.sv
